// ===== rtl/core/sti_pkg.sv =====
// package for the sorted table insert position block
// shared sizes, operation codes, transfer structs and controller interface types
// no dependencies
package sti_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int POS_W       = 11;
   localparam int VALUE_W     = 32;
   localparam int OP_W        = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             found;
      logic             overflow;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic append;
      logic start_search;
      logic step;
      logic finish;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;
      logic out_free;
   } status_type;

   // count or index reported modulo 2^POS_W
   function automatic logic [POS_W-1:0] to_pos(input logic [COUNT_W-1:0] v);
      logic [POS_W+COUNT_W-1:0] w;
      w = {{POS_W{1'b0}}, v};
      return w[POS_W-1:0];
   endfunction

endpackage

// ===== rtl/core/sti_ctrl.sv =====
// controller state machine for the sorted table insert position block
// sequences append, clear and the binary search; depends on sti_pkg
module sti_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [sti_pkg::OP_W-1:0] req_op,
   input  sti_pkg::status_type  status,
   output sti_pkg::cmd_type     cmd,
   output logic                 req_stall
);
   import sti_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_HOLD   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // input side only open while idle
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  OP_APPEND: begin
                     cmd.append = 1'b1;
                     state_in   = ST_HOLD;
                  end
                  OP_SEARCH: begin
                     cmd.start_search = 1'b1;
                     state_in         = ST_SEARCH;
                  end
                  default: begin
                     // unused code, dropped
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (status.done) begin
               cmd.finish = 1'b1;
               state_in   = ST_HOLD;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_HOLD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/sti_dp.sv =====
// datapath for the sorted table insert position block
// entry memory, fill count, search bounds and result register; depends on sti_pkg
module sti_dp (
   input  logic                clock,
   input  logic                reset,
   input  sti_pkg::req_type    req_data,
   input  sti_pkg::cmd_type    cmd,
   input  logic                rsp_stall,
   output sti_pkg::status_type status,
   output logic                rsp_valid,
   output sti_pkg::rsp_type    rsp_data
);
   import sti_pkg::*;

   logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
   logic signed [VALUE_W-1:0] rdata_ff;
   logic [ADDR_W-1:0]         raddr;

   logic [COUNT_W-1:0]        count_ff, count_in;
   logic signed [VALUE_W-1:0] key_ff;
   logic [COUNT_W-1:0]        lo_ff, lo_in;
   logic [COUNT_W-1:0]        hi_ff, hi_in;
   logic [COUNT_W-1:0]        mid_ff, mid_in;
   logic [COUNT_W-1:0]        step_lo, step_hi, step_mid;
   rsp_type                   res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff;

   logic full;
   logic empty_range;
   logic hit;
   logic key_lt;

   assign full        = (count_ff == COUNT_W'(TABLE_DEPTH));
   assign empty_range = (lo_ff >= hi_ff);
   assign hit         = (rdata_ff == key_ff);
   assign key_lt      = (key_ff < rdata_ff);

   assign status.done     = empty_range || hit;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // one probe: narrow the open interval and pick the next middle
   always_comb begin
      step_lo  = lo_ff;
      step_hi  = hi_ff;
      if (key_lt) begin
         step_hi = mid_ff;
      end else begin
         step_lo = mid_ff + COUNT_W'(1);
      end
      step_mid = step_lo + ((step_hi - step_lo - COUNT_W'(1)) >> 1);
   end

   // bounds, count and staged result
   always_comb begin
      count_in = count_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      res_in   = res_ff;
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.append) begin
         res_in.position = to_pos(count_ff);
         res_in.found    = 1'b0;
         res_in.overflow = full;
         if (!full) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
      if (cmd.start_search) begin
         lo_in  = '0;
         hi_in  = count_ff;
         mid_in = (count_ff - COUNT_W'(1)) >> 1;
      end
      if (cmd.step) begin
         lo_in  = step_lo;
         hi_in  = step_hi;
         mid_in = step_mid;
      end
      if (cmd.finish) begin
         res_in.overflow = 1'b0;
         if (empty_range) begin
            res_in.position = to_pos(lo_ff);
            res_in.found    = 1'b0;
         end else begin
            res_in.position = to_pos(mid_ff);
            res_in.found    = 1'b1;
         end
      end
   end

   // read address follows the middle about to be probed
   assign raddr = mid_in[ADDR_W-1:0];

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.append && !full) begin
         mem[count_ff[ADDR_W-1:0]] <= req_data.value;
      end
      rdata_ff <= mem[raddr];
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      res_ff <= res_in;
      if (cmd.start_search) begin
         key_ff <= req_data.value;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/sorted_table_insert_position.sv =====
// sorted table insert position, top level
// append: result staged, then loaded into the output register; search over n
// entries: k probes, k at most floor(log2 n)+1, ending on a hit or an empty range
// one item at a time; after an append or a search, the next transfer is taken
// once the result is in the output register
// probe rate set by the single read port of the entry memory, one probe a cycle
// synchronous reset empties the table and the output; entry contents are kept
module sorted_table_insert_position (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sti_pkg::rsp_type rsp_data
);
   import sti_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing
   sti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // storage and search arithmetic
   sti_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/sti_check.sv =====
// port checker for the sorted table insert position block
// bound to the top level; depends on sti_pkg
module sti_check (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sti_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sti_pkg::rsp_type rsp_data
);
   import sti_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a result is never both a hit and a dropped append
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.found && rsp_data.overflow))
      else $error("found and overflow together");

   // append or search transfer closes the input side next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.operation == OP_APPEND || req_data.operation == OP_SEARCH)
      |=> req_stall)
      else $error("input open while item in flight");

   // a dropped append reports the full count
   a_overflow_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.position == to_pos(COUNT_W'(TABLE_DEPTH)))
      else $error("overflow position not the table depth");

endmodule

bind sorted_table_insert_position sti_check u_sti_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
